// ===== src/srcp_pkg.sv =====
`default_nettype none

package srcp_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // column saturates here; the fourth character has been seen
  localparam logic [2:0] COL_SAT    = 3'd4;
  localparam logic [2:0] COL_DIGITS = 3'd3;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_CLOSED    = 2'd2
  } status_t;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef struct packed {
    logic [2:0] column;
    logic [3:0] first_digit;
    logic       digits_bad;
    logic       is_continuation;
  } line_state_t;

  typedef struct packed {
    logic       emit;
    status_t    status;
    logic [3:0] reply_class;
  } report_t;

  function automatic line_state_t take_char(line_state_t s, logic [7:0] c);
    line_state_t n;
    logic        dig;
    n   = s;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (s.column < COL_DIGITS) begin
      if (!dig) n.digits_bad = 1'b1;
      if (s.column == 3'd0) n.first_digit = dig ? c[3:0] : 4'd0;
    end else if (s.column == COL_DIGITS) begin
      n.is_continuation = (c == CH_DASH);
    end
    if (s.column < COL_SAT) n.column = s.column + 3'd1;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/srcp_if.sv =====
`default_nettype none

// byte request channel
interface srcp_rx_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// report channel
interface srcp_rpt_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] reply_class;

  modport source (output valid, output status, output reply_class, input ready);
  modport sink   (input valid, input status, input reply_class, output ready);
endinterface

`default_nettype wire

// ===== src/srcp_step.sv =====
`default_nettype none

// Next line state and report for one request.
module srcp_step (
  input  wire srcp_pkg::line_state_t line,
  input  wire                        cr_pending,
  input  wire                        op,
  input  wire [7:0]                  rx_byte,
  output srcp_pkg::line_state_t      line_next,
  output logic                       cr_pending_next,
  output srcp_pkg::report_t          report
);
  import srcp_pkg::*;

  line_state_t s;
  logic        do_end;
  logic        lf_after_cr;

  always_comb begin
    s               = line;
    cr_pending_next = cr_pending;
    do_end          = 1'b0;
    lf_after_cr     = 1'b0;
    report          = '{emit: 1'b0, status: ST_DONE, reply_class: 4'd0};

    if (op == OP_CLOSE) begin
      report          = '{emit: 1'b1, status: ST_CLOSED, reply_class: 4'd0};
      s               = '0;
      cr_pending_next = 1'b0;
    end else begin
      if (cr_pending) begin
        cr_pending_next = 1'b0;
        if (rx_byte == CH_LF) begin
          do_end      = 1'b1;
          lf_after_cr = 1'b1;
        end else begin
          // lone CR is an ordinary character
          s = take_char(s, CH_CR);
        end
      end
      if (!lf_after_cr) begin
        if (rx_byte == CH_CR) cr_pending_next = 1'b1;
        else if (rx_byte == CH_LF) do_end = 1'b1;
        else s = take_char(s, rx_byte);
      end
      if (do_end) begin
        if (s.column < COL_DIGITS || s.digits_bad) begin
          report = '{emit: 1'b1, status: ST_MALFORMED, reply_class: 4'd0};
        end else if (!(s.column >= COL_SAT && s.is_continuation)) begin
          report = '{emit: 1'b1, status: ST_DONE, reply_class: s.first_digit};
        end
        s = '0;
      end
    end
  end

  assign line_next = s;

endmodule

`default_nettype wire

// ===== src/srcp_out_reg.sv =====
`default_nettype none

// Result register; frees itself when the report is taken.
module srcp_out_reg (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  wire srcp_pkg::report_t report,
  output logic                   free,
  srcp_rpt_if.source             rpt
);
  import srcp_pkg::*;

  logic       valid;
  logic [1:0] status;
  logic [3:0] reply_class;

  assign free = !valid || rpt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= report.emit;
    end else if (rpt.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && report.emit) begin
      status      <= report.status;
      reply_class <= report.reply_class;
    end
  end

  assign rpt.valid       = valid;
  assign rpt.status      = status;
  assign rpt.reply_class = reply_class;

endmodule

`default_nettype wire

// ===== src/smtp_reply_code_parser_top.sv =====
// A report appears in the cycle after the request that causes it.
// Throughput: one request per cycle; the result register drains while the next
//   request is taken, so only a stalled report holds off new requests.
// Reset (rst, synchronous, active high) clears the line state, the pending CR
//   and the report valid flag.
`default_nettype none

module smtp_reply_code_parser_top (
  input  wire        clk,
  input  wire        rst,
  srcp_rx_if.sink    rx,
  srcp_rpt_if.source rpt
);
  import srcp_pkg::*;

  // parse state
  line_state_t line;
  logic        cr_pending;
  line_state_t line_next;
  logic        cr_pending_next;
  report_t     report;
  logic        free;
  logic        take;

  // a request goes in whenever the result register can hold its report
  assign rx.ready = free;
  assign take     = rx.valid && free;

  srcp_step u_step (
    .line            (line),
    .cr_pending      (cr_pending),
    .op              (rx.op),
    .rx_byte         (rx.rx_byte),
    .line_next       (line_next),
    .cr_pending_next (cr_pending_next),
    .report          (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line       <= '0;
      cr_pending <= 1'b0;
    end else if (take) begin
      line       <= line_next;
      cr_pending <= cr_pending_next;
    end
  end

  srcp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .report (report),
    .free   (free),
    .rpt    (rpt)
  );

  // close always yields a closed report next cycle
  a_close_report: assert property (@(posedge clk) disable iff (rst)
    take && rx.op |=> rpt.valid && rpt.status == ST_CLOSED)
    else $error("close without closed report");

  // close clears the whole parse state
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    take && rx.op |=> line == '0 && !cr_pending)
    else $error("close left parse state");

  // class only on a completed reply
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    rpt.valid && rpt.status != ST_DONE |-> rpt.reply_class == 4'd0)
    else $error("class on error report");

  // empty result register never stalls requests
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rpt.valid |-> rx.ready)
    else $error("stall with empty result register");

  // column stays within its saturation limit
  a_column_sat: assert property (@(posedge clk) disable iff (rst)
    line.column <= COL_SAT)
    else $error("column beyond limit");

endmodule

`default_nettype wire

// ===== sim/smtp_reply_code_parser_top_test.sv =====
`default_nettype none

// Self-checking bench for the SMTP reply-code parser.
// A directed burst covers the corner cases: bare three-digit codes, long digit
// runs, continuation lines, short lines, non-ASCII bytes, a stray CR and a close
// event arriving mid-line. Random mail-server traffic follows: mostly
// well-formed multi-line replies, plus noise bursts and close events.
// Every accepted request is run through a local parse model, and each report
// that the block hands out is compared with the oldest prediction.

module smtp_reply_code_parser_top_test;
  import srcp_pkg::*;

  localparam int REPLY_ITEMS = 608;   // random requests per pacing phase
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } rx_req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] reply_class;
  } reply_rpt_t;

  // parse model state, kept apart from the block's own registers
  typedef struct packed {
    logic [2:0] column;
    logic [3:0] lead_digit;
    logic       bad_digits;
    logic       dash_seen;
    logic       cr_held;
  } parse_state_t;

  logic clk;
  logic rst;

  srcp_rx_if  rx_ch ();
  srcp_rpt_if rpt_ch ();

  smtp_reply_code_parser_top uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .rpt (rpt_ch)
  );

  rx_req_t      bytes_to_send[$];   // requests waiting for the driver
  reply_rpt_t   reports_due[$];     // predicted reports, oldest first
  parse_state_t ps;

  int  src_idle_pct;
  int  snk_idle_pct;
  int  n_queued;
  int  n_taken;
  int  n_reports;
  int  n_status[3];
  int  err_count;
  bit  req_taken;

  // ---------------------------------------------------------------------
  // Parse model
  // ---------------------------------------------------------------------

  // One ordinary line character: the first three must be digits, the
  // fourth decides whether another line of the same reply follows.
  function void count_char(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (ps.column < COL_DIGITS) begin
      if (!is_digit) ps.bad_digits = 1'b1;
      if (ps.column == 3'd0) ps.lead_digit = is_digit ? 4'(c - CH_ZERO) : 4'd0;
    end else if (ps.column == COL_DIGITS) begin
      ps.dash_seen = (c == CH_DASH);
    end
    if (ps.column < COL_SAT) ps.column = ps.column + 3'd1;
  endfunction

  // Line terminator seen; returns 1 when a report is due.
  function bit end_of_line(output reply_rpt_t r);
    bit hit;
    r = '{ST_DONE, 4'd0};
    if (ps.column < COL_DIGITS || ps.bad_digits) begin
      hit = 1'b1;
      r.status = ST_MALFORMED;
    end else if (ps.column == COL_SAT && ps.dash_seen) begin
      hit = 1'b0;                 // continuation line, reply still open
    end else begin
      hit = 1'b1;
      r.reply_class = ps.lead_digit;
    end
    ps.column     = 3'd0;
    ps.lead_digit = 4'd0;
    ps.bad_digits = 1'b0;
    ps.dash_seen  = 1'b0;
    return hit;
  endfunction

  function bit parse_step(rx_req_t req, output reply_rpt_t r);
    r = '{ST_DONE, 4'd0};
    if (req.op == OP_CLOSE) begin
      // close drops any partial line and any pending CR
      ps = '0;
      r.status = ST_CLOSED;
      return 1'b1;
    end
    if (ps.cr_held) begin
      ps.cr_held = 1'b0;
      if (req.data == CH_LF) return end_of_line(r);
      count_char(CH_CR);          // bare CR is just a line character
    end
    if (req.data == CH_CR) begin
      ps.cr_held = 1'b1;
      return 1'b0;
    end
    if (req.data == CH_LF) return end_of_line(r);
    count_char(req.data);
    return 1'b0;
  endfunction

  task automatic flag_mismatch(string msg);
    if (err_count < MAX_PRINTS)
      $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Well beyond the slowest legal run (~2k requests, each held up by
  // sender gaps and stalled reports): ends a hung run.
  initial begin
    #2_000_000;
    $display("[smtp_reply_code_parser_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: request side changes on the falling edge. A request stays up
  // until it is taken; only then is the next one (or a gap) chosen.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    rx_req_t nxt;
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.op      <= OP_BYTE;
      rx_ch.rx_byte <= 8'h00;
      rpt_ch.ready  <= 1'b0;
    end else begin
      if (rx_ch.valid && !req_taken) begin
        // still waiting for the handshake, hold everything
      end else if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = bytes_to_send.pop_front();
        rx_ch.valid   <= 1'b1;
        rx_ch.op      <= nxt.op;
        rx_ch.rx_byte <= nxt.data;
      end else begin
        rx_ch.valid <= 1'b0;
      end
      rpt_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge. Reports are checked
  // before the request of the same edge is predicted, since a report
  // always belongs to an earlier request.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    reply_rpt_t want;
    reply_rpt_t got;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (rpt_ch.valid && rpt_ch.ready) begin
        n_reports++;
        if (reports_due.size() == 0) begin
          flag_mismatch($sformatf("report with nothing pending (status %0d class %0d)",
                                  rpt_ch.status, rpt_ch.reply_class));
        end else begin
          want = reports_due.pop_front();
          if (rpt_ch.status <= 2'd2) n_status[rpt_ch.status]++;
          if (rpt_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, predicted %0d",
                                    rpt_ch.status, want.status));
          if (rpt_ch.reply_class !== want.reply_class)
            flag_mismatch($sformatf("reply_class %0d, predicted %0d",
                                    rpt_ch.reply_class, want.reply_class));
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        n_taken++;
        if (parse_step('{op_t'(rx_ch.op), rx_ch.rx_byte}, got))
          reports_due.push_back(got);
      end
      req_taken <= rx_ch.valid && rx_ch.ready;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_byte(logic [7:0] b);
    bytes_to_send.push_back('{OP_BYTE, b});
    n_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_close();
    bytes_to_send.push_back('{OP_CLOSE, 8'($urandom_range(0, 255))});
    n_queued++;
  endtask

  // terse: CR LF most of the time, bare LF otherwise
  task automatic add_eol();
    if ($urandom_range(0, 9) < 7) add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  // A multi-line reply with random content; now and then a digit is
  // spoilt or the link drops part way through.
  task automatic add_reply();
    int         n_cont;
    int         n_text;
    logic [3:0] cls;
    logic [7:0] code[3];
    n_cont = $urandom_range(0, 3);
    cls    = 4'($urandom_range(0, 9));
    for (int ln = 0; ln <= n_cont; ln++) begin
      code[0] = CH_ZERO + cls;
      code[1] = CH_ZERO + 8'($urandom_range(0, 9));
      code[2] = CH_ZERO + 8'($urandom_range(0, 9));
      if ($urandom_range(0, 99) < 8) code[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
      foreach (code[i]) add_byte(code[i]);
      if (ln < n_cont) begin
        add_byte(CH_DASH);
      end else begin
        case ($urandom_range(0, 5))
          0:       ;                                   // bare code
          1:       add_byte(8'($urandom_range(0, 255)));
          default: add_byte(8'h20);
        endcase
      end
      n_text = $urandom_range(0, 5);
      for (int i = 0; i < n_text; i++) begin
        if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
        else                           add_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      if ($urandom_range(0, 99) < 3) begin
        add_close();
        return;
      end
      add_eol();
    end
  endtask

  // line noise: arbitrary bytes with plenty of terminators mixed in
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       add_byte(CH_LF);
        1:       add_byte(CH_CR);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_taken != n_queued || reports_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    int start;
    int pick;
    rx_ch.valid   = 1'b0;
    rx_ch.op      = OP_BYTE;
    rx_ch.rx_byte = 8'h00;
    rpt_ch.ready  = 1'b0;
    ps            = '0;
    src_idle_pct  = 10;
    snk_idle_pct  = 66;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: plain three-digit code with CR LF
    add_text("250");
    add_byte(CH_CR);
    add_byte(CH_LF);
    // long digit run: class stays the first digit
    add_text("9999");
    add_byte(CH_LF);
    // continuation line, no report
    add_text("123-");
    add_byte(CH_LF);
    // empty line is short, hence malformed
    add_byte(CH_LF);
    // NUL and 0xFF among the code characters
    add_byte(CH_ZERO);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_LF);
    // bare CR counted as a character, then CR LF ends a one-char line
    add_byte(CH_CR);
    add_byte(CH_CR);
    add_byte(CH_LF);
    // close mid-line with a CR pending
    add_byte(CH_ZERO + 8'd5);
    add_byte(CH_CR);
    add_close();
    wait_drained();

    // three pacing phases: slow receiver, slow sender, then flat out
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 66 : 0;
      snk_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 10 : 0;
      start = n_queued;
      while (n_queued - start < REPLY_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)      add_reply();
        else if (pick < 93) add_noise();
        else                add_close();
      end
      wait_drained();
    end

    // allow a stray late report to show up before the verdict
    repeat (4) @(posedge clk);

    $display("%0d requests over three pacing phases, %0d reports checked", n_taken, n_reports);
    $display("  complete %0d, malformed %0d, closed %0d",
             n_status[0], n_status[1], n_status[2]);
    if (err_count == 0)
      $display("[smtp_reply_code_parser_top] OK");
    else
      $display("[smtp_reply_code_parser_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/srcp_pkg.sv
src/srcp_if.sv
src/srcp_step.sv
src/srcp_out_reg.sv
src/smtp_reply_code_parser_top.sv
sim/smtp_reply_code_parser_top_test.sv
